### rtl/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants of the serial frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package sfd_pkg;

   localparam logic [7:0] HDR_FIRST  = 8'h55;
   localparam logic [7:0] HDR_SECOND = 8'hAA;
   localparam logic [7:0] LATCH_IDLE = 8'hFF;

   // most payload bytes in one frame (byte_index is 5 bits)
   localparam int MAX_PAYLOAD = 30;

   localparam logic OP_RX_BYTE     = 1'b0;
   localparam logic OP_CLEAR_LATCH = 1'b1;

   localparam logic [1:0] STATUS_PAYLOAD = 2'd0;
   localparam logic [1:0] STATUS_EMPTY   = 2'd1;
   localparam logic [1:0] STATUS_BAD_CHK = 2'd2;
   localparam logic [1:0] STATUS_BAD_LEN = 2'd3;

   typedef enum logic [2:0] {
      ST_HUNT0,
      ST_HUNT1,
      ST_LEN,
      ST_ID,
      ST_DATA,
      ST_CHECK,
      ST_EMIT_RD,
      ST_EMIT_WR
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic       clear_latch;
      logic       take_len;
      logic       take_id;
      logic       take_data;
      logic       check_cmd;
      logic       out_load;
      logic [1:0] out_status;
      logic       emit_start;
      logic       emit_rd;
      logic       emit_load;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic hdr_first;
      logic hdr_second;
      logic len_bad;
      logic len_one;
      logic data_done;
      logic xor_match;
      logic emit_last;
      logic out_free;
   } stat_type;

endpackage

`default_nettype wire

### rtl/sfd_if.sv
// ----------------------------------------------------------------------------
// sfd_if
// Valid/ready channels of the deframer: byte input, result output, CSR write.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfd_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [7:0] rx_byte;
   modport source (output valid, output opcode, output rx_byte, input ready);
   modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface sfd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [7:0] ident;
   logic [7:0] payload_byte;
   logic [4:0] byte_index;
   logic       last;
   logic [7:0] command;
   modport source (output valid, output status, output ident, output payload_byte,
                   output byte_index, output last, output command, input ready);
   modport sink   (input valid, input status, input ident, input payload_byte,
                   input byte_index, input last, input command, output ready);
endinterface

interface sfd_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/sfd_ctrl.sv
// ----------------------------------------------------------------------------
// sfd_ctrl
// Frame hunting state machine; issues datapath commands per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_opcode,
   output logic                  req_ready,
   input  wire sfd_pkg::stat_type stat,
   output sfd_pkg::cmd_type      cmd
);

   sfd_pkg::state_type state_ff, state_in;
   logic               accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sfd_pkg::ST_HUNT0;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      req_ready = (state_ff != sfd_pkg::ST_EMIT_RD) && (state_ff != sfd_pkg::ST_EMIT_WR)
                  && stat.out_free;
      accept    = req_valid && req_ready;
      state_in  = state_ff;
      cmd       = '0;
      if (accept && (req_opcode == sfd_pkg::OP_CLEAR_LATCH)) begin
         cmd.clear_latch = 1'b1;
      end else begin
         case (state_ff)
            sfd_pkg::ST_HUNT0: begin
               if (accept && stat.hdr_first) state_in = sfd_pkg::ST_HUNT1;
            end
            sfd_pkg::ST_HUNT1: begin
               if (accept) state_in = stat.hdr_second ? sfd_pkg::ST_LEN : sfd_pkg::ST_HUNT0;
            end
            sfd_pkg::ST_LEN: begin
               if (accept) begin
                  if (stat.len_bad) begin
                     cmd.out_load   = 1'b1;
                     cmd.out_status = sfd_pkg::STATUS_BAD_LEN;
                     state_in       = sfd_pkg::ST_HUNT0;
                  end else begin
                     cmd.take_len = 1'b1;
                     state_in     = sfd_pkg::ST_ID;
                  end
               end
            end
            sfd_pkg::ST_ID: begin
               if (accept) begin
                  cmd.take_id = 1'b1;
                  state_in    = stat.len_one ? sfd_pkg::ST_CHECK : sfd_pkg::ST_DATA;
               end
            end
            sfd_pkg::ST_DATA: begin
               if (accept) begin
                  cmd.take_data = 1'b1;
                  if (stat.data_done) state_in = sfd_pkg::ST_CHECK;
               end
            end
            sfd_pkg::ST_CHECK: begin
               if (accept) begin
                  state_in = sfd_pkg::ST_HUNT0;
                  if (!stat.xor_match) begin
                     cmd.out_load   = 1'b1;
                     cmd.out_status = sfd_pkg::STATUS_BAD_CHK;
                  end else if (stat.len_one) begin
                     cmd.out_load   = 1'b1;
                     cmd.out_status = sfd_pkg::STATUS_EMPTY;
                  end else begin
                     cmd.check_cmd  = 1'b1;
                     cmd.emit_start = 1'b1;
                     state_in       = sfd_pkg::ST_EMIT_RD;
                  end
               end
            end
            sfd_pkg::ST_EMIT_RD: begin
               cmd.emit_rd = 1'b1;
               state_in    = sfd_pkg::ST_EMIT_WR;
            end
            sfd_pkg::ST_EMIT_WR: begin
               if (stat.out_free) begin
                  cmd.emit_load = 1'b1;
                  state_in      = stat.emit_last ? sfd_pkg::ST_HUNT0 : sfd_pkg::ST_EMIT_RD;
               end
            end
            default: state_in = sfd_pkg::ST_HUNT0;
         endcase
      end
   end

endmodule

`default_nettype wire

### rtl/sfd_datapath.sv
// ----------------------------------------------------------------------------
// sfd_datapath
// Frame registers, payload store, running XOR, command latch, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_datapath #(
   parameter int BUF_DEPTH = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [7:0]       rx_byte,
   input  wire logic             csr_valid,
   input  wire logic [7:0]       csr_data,
   input  wire logic             rsp_ready,
   input  wire sfd_pkg::cmd_type cmd,
   output sfd_pkg::stat_type     stat,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_status,
   output logic [7:0]            rsp_ident,
   output logic [7:0]            rsp_payload_byte,
   output logic [4:0]            rsp_byte_index,
   output logic                  rsp_last,
   output logic [7:0]            rsp_command
);

   // longest accepted length byte, payload store depth
   localparam int         MAX_LEN_I = (BUF_DEPTH - 1 < sfd_pkg::MAX_PAYLOAD + 1) ?
                                      BUF_DEPTH - 1 : sfd_pkg::MAX_PAYLOAD + 1;
   localparam logic [7:0] MAX_LEN   = 8'(MAX_LEN_I);
   localparam int         PAY_DEPTH = MAX_LEN_I - 1;
   localparam int         IDX_W     = (PAY_DEPTH > 1) ? $clog2(PAY_DEPTH) : 1;

   logic [7:0] mem [PAY_DEPTH];
   logic [7:0] rd_ff;
   logic [4:0] len_ff;
   logic [7:0] id_ff;
   logic [4:0] count_ff;
   logic [4:0] idx_ff;
   logic [7:0] xor_ff;
   logic [7:0] first_ff;
   logic [7:0] latch_ff;
   logic [7:0] cfg_ff;
   logic       valid_ff;
   logic [1:0] status_ff;
   logic [7:0] fid_ff;
   logic [7:0] pay_ff;
   logic [4:0] bidx_ff;
   logic       last_ff;
   logic [7:0] cmdv_ff;

   always_comb begin
      stat.hdr_first  = (rx_byte == sfd_pkg::HDR_FIRST);
      stat.hdr_second = (rx_byte == sfd_pkg::HDR_SECOND);
      stat.len_bad    = (rx_byte == 8'd0) || (rx_byte > MAX_LEN);
      stat.len_one    = (len_ff == 5'd1);
      stat.data_done  = (count_ff == len_ff - 5'd2);
      stat.xor_match  = (xor_ff == rx_byte);
      stat.emit_last  = (idx_ff == len_ff - 5'd2);
      stat.out_free   = !valid_ff || rsp_ready;
   end

   // frame capture
   always_ff @(posedge clock) begin
      if (cmd.take_len) begin
         len_ff   <= rx_byte[4:0];
         xor_ff   <= rx_byte;
         count_ff <= 5'd0;
      end
      if (cmd.take_id) begin
         id_ff  <= rx_byte;
         xor_ff <= xor_ff ^ rx_byte;
      end
      if (cmd.take_data) begin
         mem[count_ff[IDX_W-1:0]] <= rx_byte;
         xor_ff   <= xor_ff ^ rx_byte;
         count_ff <= count_ff + 5'd1;
         if (count_ff == 5'd0) first_ff <= rx_byte;
      end
      if (cmd.emit_start) idx_ff <= 5'd0;
      if (cmd.emit_rd)    rd_ff  <= mem[idx_ff[IDX_W-1:0]];
      if (cmd.emit_load)  idx_ff <= idx_ff + 5'd1;
   end

   // command latch and CSR
   always_ff @(posedge clock) begin
      if (reset) begin
         latch_ff <= sfd_pkg::LATCH_IDLE;
         cfg_ff   <= 8'd0;
      end else begin
         if (csr_valid) cfg_ff <= csr_data;
         if (cmd.clear_latch) begin
            latch_ff <= sfd_pkg::LATCH_IDLE;
         end else if (cmd.check_cmd && (id_ff == cfg_ff)) begin
            latch_ff <= first_ff;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.out_load || cmd.emit_load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         status_ff <= cmd.out_status;
         fid_ff    <= (cmd.out_status == sfd_pkg::STATUS_BAD_LEN) ? 8'd0 : id_ff;
         pay_ff    <= 8'd0;
         bidx_ff   <= 5'd0;
         last_ff   <= 1'b1;
         cmdv_ff   <= latch_ff;
      end else if (cmd.emit_load) begin
         status_ff <= sfd_pkg::STATUS_PAYLOAD;
         fid_ff    <= id_ff;
         pay_ff    <= rd_ff;
         bidx_ff   <= idx_ff;
         last_ff   <= stat.emit_last;
         cmdv_ff   <= latch_ff;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_ident        = fid_ff;
   assign rsp_payload_byte = pay_ff;
   assign rsp_byte_index   = bidx_ff;
   assign rsp_last         = last_ff;
   assign rsp_command      = cmdv_ff;

   a_index_in_store: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && status_ff == sfd_pkg::STATUS_PAYLOAD) |-> (bidx_ff < 5'(PAY_DEPTH)))
      else $error("payload beat index beyond store");

   a_single_is_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && status_ff != sfd_pkg::STATUS_PAYLOAD) |-> (last_ff && pay_ff == 8'd0))
      else $error("single result not marked last");

   a_reject_zeroed: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && status_ff == sfd_pkg::STATUS_BAD_LEN) |-> (fid_ff == 8'd0 && bidx_ff == 5'd0))
      else $error("length reject carries frame fields");

   a_no_load_over_full: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_ready) |-> !(cmd.out_load || cmd.emit_load))
      else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

### rtl/serial_frame_deframer_xor_check_unit.sv
// ----------------------------------------------------------------------------
// serial_frame_deframer_xor_check_unit
// Header/length/XOR-check frame parser for a byte-serial receive link.
// ----------------------------------------------------------------------------
// Timing: a single result (empty frame, check error, length reject) is in the
//   result register the next cycle after the byte beat that decides it is taken.
// Throughput: one byte per cycle while no result waits and no burst runs; a good
//   frame of N payload bytes streams N result beats (payload store read, then load).
// Reset: synchronous, active high; hunting restarts, command latch 255, register 0.
//   The payload store needs no clearing pass.
`default_nettype none

module serial_frame_deframer_xor_check_unit #(
   parameter int BUF_DEPTH = 32
) (
   input wire logic   clock,
   input wire logic   reset,
   sfd_req_if.sink    req_bus,
   sfd_rsp_if.source  rsp_bus,
   sfd_csr_if.sink    csr_bus
);

   sfd_pkg::cmd_type  cmd;
   sfd_pkg::stat_type stat;

   // register port never stalls
   assign csr_bus.ready = 1'b1;

   // Controller: header hunt, length/id/data/check sequencing, result burst.
   // Input beats are held off during the burst and while a result is stuck.
   sfd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_opcode (req_bus.opcode),
      .req_ready  (req_bus.ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Datapath: payload store, running XOR of length/id/payload, command latch,
   // and the output register that decouples result beats from the input side.
   sfd_datapath #(
      .BUF_DEPTH (BUF_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .rx_byte          (req_bus.rx_byte),
      .csr_valid        (csr_bus.valid),
      .csr_data         (csr_bus.data),
      .rsp_ready        (rsp_bus.ready),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_valid        (rsp_bus.valid),
      .rsp_status       (rsp_bus.status),
      .rsp_ident        (rsp_bus.ident),
      .rsp_payload_byte (rsp_bus.payload_byte),
      .rsp_byte_index   (rsp_bus.byte_index),
      .rsp_last         (rsp_bus.last),
      .rsp_command      (rsp_bus.command)
   );

endmodule

`default_nettype wire

### dv/sfd_frame_checker.sv
// ----------------------------------------------------------------------------
// sfd_frame_checker
// Watches the byte, result and CSR channels of the frame deframer, tracks the
// expected result beats of every frame it sees go in, and compares each result
// beat field by field against the oldest expected one.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_frame_checker #(
   parameter int BUF_DEPTH = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   sfd_req_if        req_bus,
   sfd_rsp_if        rsp_bus,
   sfd_csr_if        csr_bus,
   output int        mismatch_count,
   output int        results_pending
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PRINT_CAP     = 200;
   // longest length byte taken: length + id + payload must fit the store
   localparam int FRAME_MAX_LEN = (BUF_DEPTH - 1 < sfd_pkg::MAX_PAYLOAD + 1) ?
                                  BUF_DEPTH - 1 : sfd_pkg::MAX_PAYLOAD + 1;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] ident;
      logic [7:0] payload_byte;
      logic [4:0] byte_index;
      logic       last;
      logic [7:0] command;
   } rsp_beat_type;

   rsp_beat_type       expected_beats [$];
   sfd_pkg::state_type parse_state;
   logic [7:0]         frame_bytes [0:FRAME_MAX_LEN];
   int                 bytes_held;
   logic [7:0]         len_byte;
   logic [7:0]         frame_ident;
   logic [7:0]         cmd_latch;
   logic [7:0]         match_id;

   function automatic void expect_beat(input logic [1:0] status, input logic [7:0] id,
                                       input logic [7:0] data, input logic [4:0] index,
                                       input logic is_last);
      expected_beats.push_back('{status, id, data, index, is_last, cmd_latch});
   endfunction

   // one accepted byte beat through the deframer
   task automatic parse_beat(input logic op, input logic [7:0] b);
      logic [7:0] xor_sum;
      int         payload_len;
      if (op == sfd_pkg::OP_CLEAR_LATCH) begin
         cmd_latch = sfd_pkg::LATCH_IDLE;
         return;
      end
      case (parse_state)
         sfd_pkg::ST_HUNT0: begin
            if (b == sfd_pkg::HDR_FIRST) parse_state = sfd_pkg::ST_HUNT1;
         end
         sfd_pkg::ST_HUNT1: begin
            parse_state = (b == sfd_pkg::HDR_SECOND) ? sfd_pkg::ST_LEN : sfd_pkg::ST_HUNT0;
         end
         sfd_pkg::ST_LEN: begin
            if (b == 8'd0 || b > FRAME_MAX_LEN) begin
               expect_beat(sfd_pkg::STATUS_BAD_LEN, 8'h00, 8'h00, 5'd0, 1'b1);
               parse_state = sfd_pkg::ST_HUNT0;
            end else begin
               len_byte       = b;
               frame_bytes[0] = b;
               bytes_held     = 1;
               parse_state    = sfd_pkg::ST_ID;
            end
         end
         sfd_pkg::ST_ID: begin
            frame_ident    = b;
            frame_bytes[1] = b;
            bytes_held     = 2;
            parse_state    = (len_byte == 8'd1) ? sfd_pkg::ST_CHECK : sfd_pkg::ST_DATA;
         end
         sfd_pkg::ST_DATA: begin
            frame_bytes[bytes_held] = b;
            bytes_held++;
            if (bytes_held >= len_byte + 1) parse_state = sfd_pkg::ST_CHECK;
         end
         sfd_pkg::ST_CHECK: begin
            xor_sum = 8'h00;
            for (int k = 0; k <= len_byte; k++) xor_sum ^= frame_bytes[k];
            if (xor_sum != b) begin
               expect_beat(sfd_pkg::STATUS_BAD_CHK, frame_ident, 8'h00, 5'd0, 1'b1);
            end else if (len_byte == 8'd1) begin
               expect_beat(sfd_pkg::STATUS_EMPTY, frame_ident, 8'h00, 5'd0, 1'b1);
            end else begin
               payload_len = len_byte - 1;
               // latch moves before the burst, so every beat carries the new value
               if (frame_ident == match_id) cmd_latch = frame_bytes[2];
               for (int k = 0; k < payload_len; k++)
                  expect_beat(sfd_pkg::STATUS_PAYLOAD, frame_ident, frame_bytes[2 + k],
                              5'(k), k == payload_len - 1);
            end
            bytes_held  = 0;
            parse_state = sfd_pkg::ST_HUNT0;
         end
         default: begin
            parse_state = sfd_pkg::ST_HUNT0;
         end
      endcase
   endtask

   task automatic report_mismatch(input string what);
      mismatch_count++;
      // quiet after the cap so a dead block cannot flood the log
      if (mismatch_count <= PRINT_CAP) $display("[%0t] deframer mismatch: %s", $time, what);
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want) report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
   endtask

   task automatic check_rsp_beat();
      rsp_beat_type want;
      if (expected_beats.size() == 0) begin
         report_mismatch("result beat with nothing expected");
         return;
      end
      want = expected_beats.pop_front();
      check_field("status", rsp_bus.status, want.status);
      check_field("ident", rsp_bus.ident, want.ident);
      check_field("payload_byte", rsp_bus.payload_byte, want.payload_byte);
      check_field("byte_index", rsp_bus.byte_index, want.byte_index);
      check_field("last", rsp_bus.last, want.last);
      check_field("command", rsp_bus.command, want.command);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_beats.delete();
         parse_state     = sfd_pkg::ST_HUNT0;
         bytes_held      = 0;
         len_byte        = 8'h00;
         frame_ident     = 8'h00;
         cmd_latch       = sfd_pkg::LATCH_IDLE;
         match_id        = 8'h00;
         mismatch_count  = 0;
         results_pending <= 0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) match_id = csr_bus.data;
         if (rsp_bus.valid && rsp_bus.ready) check_rsp_beat();
         if (req_bus.valid && req_bus.ready) parse_beat(req_bus.opcode, req_bus.rx_byte);
         results_pending <= expected_beats.size();
      end
   end

endmodule

`default_nettype wire

### dv/serial_frame_deframer_xor_check_unit_tb.sv
// ----------------------------------------------------------------------------
// serial_frame_deframer_xor_check_unit_tb
// Drives byte beats into the frame deframer: a short directed pass over the
// header, length and check corner cases, then random frames (mostly well formed,
// some broken, some noise) under several command id settings, with random
// stalls on both channels. The checker beside the block judges every result.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_frame_deframer_xor_check_unit_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int BUF_DEPTH       = 32;
   localparam int FRAME_MAX_LEN   = (BUF_DEPTH - 1 < sfd_pkg::MAX_PAYLOAD + 1) ?
                                    BUF_DEPTH - 1 : sfd_pkg::MAX_PAYLOAD + 1;
   localparam int RANDOM_ITEMS    = 350;
   localparam int HOLD_OFF_CYCLES = 300;   // long receiver stall, fills the block
   localparam int SETTLE_CYCLES   = 4;     // quiet time before a CSR write
   localparam int DRAIN_CYCLES    = 40;    // a few emit bursts' worth

   logic clock = 1'b0;
   logic reset;

   sfd_req_if req_bus ();
   sfd_rsp_if rsp_bus ();
   sfd_csr_if csr_bus ();

   int mismatch_count;
   int results_pending;

   // stimulus controls
   bit         steady_flow  = 1'b0;   // no idling on either side
   bit         hold_request = 1'b0;   // ask the receiver for one long stall
   bit         mix_clears   = 1'b0;   // sprinkle latch clears between bytes
   int         items_sent   = 0;
   logic [7:0] match_id     = 8'h00;  // our copy of command_frame_id

   serial_frame_deframer_xor_check_unit #(
      .BUF_DEPTH(BUF_DEPTH)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   sfd_frame_checker #(
      .BUF_DEPTH(BUF_DEPTH)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_bus        (csr_bus),
      .mismatch_count (mismatch_count),
      .results_pending(results_pending)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Gap length: mostly from the shortest range, now and then a longer pause.
   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // ------------------------------------------------------------------------
   // Byte channel. Every task starts and ends on a rising edge; valid stays
   // high across back-to-back beats so it is never dropped and raised in the
   // same step.
   // ------------------------------------------------------------------------
   task automatic send_beat(input logic op, input logic [7:0] b);
      int gap;
      req_bus.valid   <= 1'b1;
      req_bus.opcode  <= op;
      req_bus.rx_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
      gap = 0;
      if (!steady_flow && $urandom_range(0, 99) < 30) gap = idle_span();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // a received byte, with an occasional latch clear slipped in ahead of it
   task automatic send_rx(input logic [7:0] b);
      if (mix_clears && $urandom_range(0, 99) < 4)
         send_beat(sfd_pkg::OP_CLEAR_LATCH, 8'($urandom_range(0, 255)));
      send_beat(sfd_pkg::OP_RX_BYTE, b);
   endtask

   // Full frame: header, length, id, length-1 payload bytes, check byte.
   task automatic send_packet(input logic [7:0] len, input logic [7:0] ident,
                              input bit corrupt);
      logic [7:0] chk;
      logic [7:0] b;
      chk = len ^ ident;
      send_rx(sfd_pkg::HDR_FIRST);
      send_rx(sfd_pkg::HDR_SECOND);
      send_rx(len);
      send_rx(ident);
      for (int i = 1; i < len; i++) begin
         b = 8'($urandom_range(0, 255));
         chk ^= b;
         send_rx(b);
      end
      // nonzero flip, so a corrupted check can never match by luck
      if (corrupt) chk ^= 8'($urandom_range(1, 255));
      send_rx(chk);
   endtask

   // ------------------------------------------------------------------------
   // Phase boundaries: stop offering, wait for every expected result, settle,
   // then write the command id.
   // ------------------------------------------------------------------------
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      // pending count is registered, so sample from the next edge on
      do @(posedge clock); while (results_pending != 0);
   endtask

   task automatic write_match_id(input logic [7:0] value);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      match_id = value;
   endtask

   // ------------------------------------------------------------------------
   // Directed corner cases, run with the command id at its reset value 0.
   // ------------------------------------------------------------------------
   task automatic run_directed();
      send_beat(sfd_pkg::OP_CLEAR_LATCH, 8'h00);              // clear, latch already idle
      send_beat(sfd_pkg::OP_RX_BYTE, sfd_pkg::HDR_FIRST);     // header mismatch
      send_beat(sfd_pkg::OP_RX_BYTE, 8'h12);
      send_beat(sfd_pkg::OP_RX_BYTE, sfd_pkg::HDR_FIRST);     // 0x55 0x55 0xAA: second
      send_beat(sfd_pkg::OP_RX_BYTE, sfd_pkg::HDR_FIRST);     // 0x55 is not a new start
      send_beat(sfd_pkg::OP_RX_BYTE, sfd_pkg::HDR_SECOND);
      send_beat(sfd_pkg::OP_RX_BYTE, sfd_pkg::HDR_FIRST);     // zero length
      send_beat(sfd_pkg::OP_RX_BYTE, sfd_pkg::HDR_SECOND);
      send_beat(sfd_pkg::OP_RX_BYTE, 8'h00);
      send_beat(sfd_pkg::OP_RX_BYTE, sfd_pkg::HDR_FIRST);     // length far past the store
      send_beat(sfd_pkg::OP_RX_BYTE, sfd_pkg::HDR_SECOND);
      send_beat(sfd_pkg::OP_RX_BYTE, 8'hFF);
      send_packet(8'd1, 8'h00, 1'b0);                         // empty frame, id matches,
                                                              // latch must stay idle
      send_packet(8'd2, 8'h00, 1'b0);                         // one byte, loads the latch
      send_beat(sfd_pkg::OP_CLEAR_LATCH, 8'hFF);              // back to idle
      send_packet(8'd1, 8'hFF, 1'b1);                         // bad check
   endtask

   // ------------------------------------------------------------------------
   // Random traffic: mostly well-formed frames with random content, plus
   // latch clears, rejected lengths, broken headers, cut-off frames and noise.
   // ------------------------------------------------------------------------
   task automatic random_unit();
      int         pick;
      int         n;
      logic [7:0] len;
      logic [7:0] ident;
      pick  = $urandom_range(0, 99);
      ident = ($urandom_range(0, 99) < 35) ? match_id : 8'($urandom_range(0, 255));
      n     = $urandom_range(0, 99);
      if (n < 10) len = 8'($urandom_range(20, FRAME_MAX_LEN));
      else if (n < 25) len = 8'd1;
      else len = 8'($urandom_range(2, 8));
      if (pick < 68) begin
         send_packet(len, ident, $urandom_range(0, 99) < 15);
      end else if (pick < 76) begin
         send_beat(sfd_pkg::OP_CLEAR_LATCH, 8'($urandom_range(0, 255)));
      end else if (pick < 83) begin
         send_rx(sfd_pkg::HDR_FIRST);
         send_rx(sfd_pkg::HDR_SECOND);
         send_rx(($urandom_range(0, 3) == 0) ? 8'h00 :
                 8'($urandom_range(FRAME_MAX_LEN + 1, 255)));
      end else if (pick < 89) begin
         send_rx(sfd_pkg::HDR_FIRST);
         send_rx(8'($urandom_range(0, 255)));
      end else if (pick < 94) begin
         // frame cut short; whatever follows lands in its payload
         send_rx(sfd_pkg::HDR_FIRST);
         send_rx(sfd_pkg::HDR_SECOND);
         send_rx(len);
         send_rx(ident);
         repeat ($urandom_range(0, len - 1)) send_rx(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(1, 4)) send_rx(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic run_random(input int upto);
      while (items_sent < upto) random_unit();
   endtask

   // ------------------------------------------------------------------------
   // Result side: random stalls, plus one long hold-off on request, counted
   // here so the sender keeps pushing while the block backs up.
   // ------------------------------------------------------------------------
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = HOLD_OFF_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (!steady_flow && $urandom_range(0, 99) < 25) stall_left = idle_span();
         end
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.opcode  <= sfd_pkg::OP_RX_BYTE;
      req_bus.rx_byte <= 8'h00;
      csr_bus.valid   <= 1'b0;
      csr_bus.data    <= 8'h00;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      wait_drained();

      // command id at the top extreme
      items_sent = 0;
      mix_clears = 1'b1;
      write_match_id(8'hFF);
      run_random(90);
      wait_drained();

      // long receiver hold while two maximum frames and more traffic go in
      write_match_id(8'($urandom_range(1, 254)));
      hold_request = 1'b1;
      send_packet(8'(FRAME_MAX_LEN), match_id, 1'b0);
      send_packet(8'(FRAME_MAX_LEN), 8'($urandom_range(0, 255)), 1'b0);
      run_random(180);
      wait_drained();

      // bottom extreme, full rate on both sides
      write_match_id(8'h00);
      steady_flow = 1'b1;
      run_random(270);
      wait_drained();

      steady_flow = 1'b0;
      write_match_id(8'($urandom_range(0, 255)));
      run_random(RANDOM_ITEMS);
      wait_drained();

      // catch any stray beats after the last expected one
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && results_pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire
